[rtl/lctp_pkg.sv]
// ----------------------------------------------------------------------------
// lctp_pkg
// Types, codes and topic tables shared by the light command parser blocks.
// ----------------------------------------------------------------------------
package lctp_pkg;

    // setting kinds
    localparam logic [1:0] KIND_BRIGHT = 2'd0;
    localparam logic [1:0] KIND_ON     = 2'd1;
    localparam logic [1:0] KIND_CCT    = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_UID_CHARS  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UID_LENGTH = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CCT_MIN    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CCT_MAX    = 4'd3;

    localparam logic [15:0] CCT_MIN_RESET = 16'd2700;
    localparam logic [15:0] CCT_MAX_RESET = 16'd6500;
    localparam logic [15:0] BRIGHT_MAX    = 16'd255;
    localparam logic [15:0] ON_MAX        = 16'd1;

    // ascii codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        out_last;
        logic [1:0]  applied_kind;
        logic [1:0]  applied_channel;
        logic [15:0] applied_value;
    } t_out;

    typedef struct packed {
        logic [63:0] uid_chars;
        logic [3:0]  uid_length;
        logic [15:0] cct_min;
        logic [15:0] cct_max;
    } t_cfg;

    // finished command handed from parser to echo sequencer
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [15:0] acc;
        logic        neg;
    } t_job;

    // command and state topics have the same length per kind
    function automatic logic [2:0] topic_len(input logic [1:0] kind);
        case (kind)
            KIND_BRIGHT: return 3'd5;
            KIND_ON:     return 3'd4;
            default:     return 3'd6;
        endcase
    endfunction

    // "/bct/", "/ct/", "/ctct/"
    function automatic logic [7:0] cmd_topic_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = "/";
        case (kind)
            KIND_BRIGHT: begin
                case (pos)
                    3'd1:    c = "b";
                    3'd2:    c = "c";
                    3'd3:    c = "t";
                    default: c = "/";
                endcase
            end
            KIND_ON: begin
                case (pos)
                    3'd1:    c = "c";
                    3'd2:    c = "t";
                    default: c = "/";
                endcase
            end
            default: begin
                case (pos)
                    3'd1:    c = "c";
                    3'd2:    c = "t";
                    3'd3:    c = "c";
                    3'd4:    c = "t";
                    default: c = "/";
                endcase
            end
        endcase
        return c;
    endfunction

    // "/bst/", "/st/", "/ctst/"
    function automatic logic [7:0] echo_topic_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = "/";
        case (kind)
            KIND_BRIGHT: begin
                case (pos)
                    3'd1:    c = "b";
                    3'd2:    c = "s";
                    3'd3:    c = "t";
                    default: c = "/";
                endcase
            end
            KIND_ON: begin
                case (pos)
                    3'd1:    c = "s";
                    3'd2:    c = "t";
                    default: c = "/";
                endcase
            end
            default: begin
                case (pos)
                    3'd1:    c = "c";
                    3'd2:    c = "t";
                    3'd3:    c = "s";
                    3'd4:    c = "t";
                    default: c = "/";
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/lctp_parser.sv]
// ----------------------------------------------------------------------------
// lctp_parser
// Byte-wise command matcher and value reader; queues one finished command.
// ----------------------------------------------------------------------------
module lctp_parser import lctp_pkg::*; #(
    parameter int unsigned UID_MAX_CHARS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    input  t_in  i_in,
    output logic o_in_stall,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_job_take
);

    localparam logic [3:0] ID_MAX_LEN = 4'(UID_MAX_CHARS);

    typedef enum logic [6:0] {
        PH_UID   = 7'b0000001,
        PH_CHAN  = 7'b0000010,
        PH_TOPIC = 7'b0000100,
        PH_PRE   = 7'b0001000,
        PH_DIG   = 7'b0010000,
        PH_DONE  = 7'b0100000,
        PH_SKIP  = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase, w_phase_eff;
    logic [3:0]  r_pos, n_pos;
    logic [2:0]  r_cand, n_cand;
    logic [1:0]  r_ch, n_ch;
    logic [15:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_job_valid;
    t_job        r_job;

    logic [7:0]  w_char;
    logic [3:0]  w_id_len;
    logic        w_is_digit;
    logic [2:0]  w_live;
    logic        w_done_hit;
    logic [1:0]  w_done_k;
    logic        w_accept;
    logic        w_finish;
    logic [1:0]  w_kind;

    assign w_char     = i_in.in_char;
    assign w_id_len   = (i_cfg.uid_length > ID_MAX_LEN) ? ID_MAX_LEN : i_cfg.uid_length;
    assign w_is_digit = w_char inside {[CH_ZERO:CH_NINE]};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_cand      = r_cand;
        n_ch        = r_ch;
        n_acc       = r_acc;
        n_neg       = r_neg;
        w_phase_eff = r_phase;
        w_live      = '0;
        w_done_hit  = 1'b0;
        w_done_k    = '0;
        if (w_char == CH_NUL) begin
            // a zero byte ends the value, anywhere else it breaks the match
            if (r_phase == PH_PRE || r_phase == PH_DIG) begin
                n_phase = PH_DONE;
            end else if (r_phase != PH_DONE) begin
                n_phase = PH_SKIP;
            end
        end else begin
            if (r_phase == PH_UID && r_pos >= w_id_len) begin
                w_phase_eff = PH_CHAN;
                n_phase     = PH_CHAN;
                n_pos       = '0;
            end
            case (w_phase_eff)
                PH_UID: begin
                    if (w_char == i_cfg.uid_chars[{r_pos[2:0], 3'b000} +: 8]) begin
                        n_pos = r_pos + 4'd1;
                        if (r_pos + 4'd1 >= w_id_len) begin
                            n_phase = PH_CHAN;
                            n_pos   = '0;
                        end
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_CHAN: begin
                    if (w_char inside {[CH_ONE:CH_FOUR]}) begin
                        n_ch    = 2'(w_char - CH_ONE);
                        n_phase = PH_TOPIC;
                        n_pos   = '0;
                        n_cand  = 3'b111;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_TOPIC: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_cand[k] && r_pos < {1'b0, topic_len(2'(k))} &&
                            cmd_topic_char(2'(k), r_pos[2:0]) == w_char) begin
                            w_live[k] = 1'b1;
                            if (r_pos + 4'd1 == {1'b0, topic_len(2'(k))}) begin
                                w_done_hit = 1'b1;
                                w_done_k   = 2'(k);
                            end
                        end
                    end
                    n_pos = r_pos + 4'd1;
                    if (w_live == 3'b000) begin
                        n_phase = PH_SKIP;
                    end else if (w_done_hit) begin
                        n_cand  = 3'b001 << w_done_k;
                        n_phase = PH_PRE;
                    end else begin
                        n_cand = w_live;
                    end
                end
                PH_PRE: begin
                    if (w_char == CH_SPACE || (w_char inside {[CH_TAB:CH_CR]})) begin
                        n_phase = PH_PRE;
                    end else if (w_char == CH_PLUS || w_char == CH_MINUS) begin
                        n_neg   = (w_char == CH_MINUS);
                        n_phase = PH_DIG;
                    end else if (w_is_digit) begin
                        n_acc   = {12'd0, w_char[3:0]};
                        n_phase = PH_DIG;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIG: begin
                    if (w_is_digit) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {12'd0, w_char[3:0]};
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_finish = (n_phase == PH_PRE) || (n_phase == PH_DIG) || (n_phase == PH_DONE);
    assign w_kind   = n_cand[0] ? KIND_BRIGHT : (n_cand[1] ? KIND_ON : KIND_CCT);

    // only a message end needs the queue slot
    assign o_in_stall = r_job_valid && i_in.in_last;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_UID;
            r_pos       <= '0;
            r_cand      <= 3'b111;
            r_ch        <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (i_in.in_last) begin
                    r_phase <= PH_UID;
                    r_pos   <= '0;
                    r_cand  <= 3'b111;
                    r_ch    <= '0;
                    r_acc   <= '0;
                    r_neg   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_cand  <= n_cand;
                    r_ch    <= n_ch;
                    r_acc   <= n_acc;
                    r_neg   <= n_neg;
                end
            end
            if (w_accept && i_in.in_last && w_finish) begin
                r_job_valid <= 1'b1;
            end else if (i_job_take) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.in_last && w_finish) begin
            r_job.kind    <= w_kind;
            r_job.channel <= n_ch;
            r_job.acc     <= n_acc;
            r_job.neg     <= n_neg;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

[rtl/lctp_echo.sv]
// ----------------------------------------------------------------------------
// lctp_echo
// Clamps a finished command and streams its state echo text into the
// output register, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lctp_echo import lctp_pkg::*; #(
    parameter int unsigned UID_MAX_CHARS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_take,
    output logic o_out_valid,
    output t_out o_out,
    input  logic i_out_stall
);

    localparam logic [3:0] ID_MAX_LEN = 4'(UID_MAX_CHARS);

    typedef enum logic [4:0] {
        SQ_IDLE  = 5'b00001,
        SQ_UID   = 5'b00010,
        SQ_CHAN  = 5'b00100,
        SQ_TOPIC = 5'b01000,
        SQ_DIGIT = 5'b10000
    } t_seq;

    t_seq        r_state, n_state;
    logic [2:0]  r_pos, n_pos;
    logic [1:0]  r_kind, n_kind;
    logic [1:0]  r_ch, n_ch;
    logic [15:0] r_value, n_value;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_k, n_k;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic [3:0]  w_id_len;
    logic        w_adv;
    logic [15:0] w_raw;
    logic [15:0] w_clamped;
    logic [2:0]  w_top_k;
    logic [3:0]  w_q;
    logic [16:0] w_sub;
    logic [7:0]  w_char;
    logic        w_emit;
    logic        w_last;

    // m times ten to the k
    function automatic logic [16:0] step_value(input logic [2:0] k, input int m);
        case (k)
            3'd0:    return 17'(m);
            3'd1:    return 17'(m * 10);
            3'd2:    return 17'(m * 100);
            3'd3:    return 17'(m * 1000);
            default: return 17'(m * 10000);
        endcase
    endfunction

    assign w_id_len = (i_cfg.uid_length > ID_MAX_LEN) ? ID_MAX_LEN : i_cfg.uid_length;
    assign w_adv    = !r_out_valid || !i_out_stall;
    assign o_job_take = (r_state == SQ_IDLE) && i_job_valid;

    assign w_raw = i_job.neg ? (16'd0 - i_job.acc) : i_job.acc;

    always_comb begin
        case (i_job.kind)
            KIND_BRIGHT: w_clamped = (w_raw > BRIGHT_MAX) ? BRIGHT_MAX : w_raw;
            KIND_ON:     w_clamped = (w_raw > ON_MAX) ? ON_MAX : w_raw;
            default: begin
                if (w_raw < i_cfg.cct_min) begin
                    w_clamped = i_cfg.cct_min;
                end else if (w_raw > i_cfg.cct_max) begin
                    w_clamped = i_cfg.cct_max;
                end else begin
                    w_clamped = w_raw;
                end
            end
        endcase
    end

    // index of the leading decimal digit
    always_comb begin
        if (r_value >= 16'd10000) begin
            w_top_k = 3'd4;
        end else if (r_value >= 16'd1000) begin
            w_top_k = 3'd3;
        end else if (r_value >= 16'd100) begin
            w_top_k = 3'd2;
        end else if (r_value >= 16'd10) begin
            w_top_k = 3'd1;
        end else begin
            w_top_k = 3'd0;
        end
    end

    // remainder stays below ten times the current power
    always_comb begin
        w_q   = '0;
        w_sub = '0;
        for (int m = 1; m < 10; m++) begin
            if ({1'b0, r_rem} >= step_value(r_k, m)) begin
                w_q   = 4'(m);
                w_sub = step_value(r_k, m);
            end
        end
    end

    always_comb begin
        case (r_state)
            SQ_UID:   w_char = i_cfg.uid_chars[{r_pos, 3'b000} +: 8];
            SQ_CHAN:  w_char = CH_ONE + {6'd0, r_ch};
            SQ_TOPIC: w_char = echo_topic_char(r_kind, r_pos);
            SQ_DIGIT: w_char = CH_ZERO + {4'd0, w_q};
            default:  w_char = CH_NUL;
        endcase
    end

    assign w_emit = w_adv && (r_state != SQ_IDLE);
    assign w_last = (r_state == SQ_DIGIT) && (r_k == 3'd0);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_ch        = r_ch;
        n_value     = r_value;
        n_rem       = r_rem;
        n_k         = r_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid           = 1'b1;
            n_out.out_char        = w_char;
            n_out.out_last        = w_last;
            n_out.applied_kind    = r_kind;
            n_out.applied_channel = r_ch;
            n_out.applied_value   = r_value;
        end
        case (r_state)
            SQ_IDLE: begin
                if (i_job_valid) begin
                    n_kind  = i_job.kind;
                    n_ch    = i_job.channel;
                    n_value = w_clamped;
                    n_pos   = '0;
                    n_state = (w_id_len == 4'd0) ? SQ_CHAN : SQ_UID;
                end
            end
            SQ_UID: begin
                if (w_adv) begin
                    n_pos = r_pos + 3'd1;
                    if ({1'b0, r_pos} + 4'd1 >= w_id_len) begin
                        n_pos   = '0;
                        n_state = SQ_CHAN;
                    end
                end
            end
            SQ_CHAN: begin
                if (w_adv) begin
                    n_rem   = r_value;
                    n_k     = w_top_k;
                    n_pos   = '0;
                    n_state = SQ_TOPIC;
                end
            end
            SQ_TOPIC: begin
                if (w_adv) begin
                    n_pos = r_pos + 3'd1;
                    if (r_pos + 3'd1 == topic_len(r_kind)) begin
                        n_state = SQ_DIGIT;
                    end
                end
            end
            SQ_DIGIT: begin
                if (w_adv) begin
                    n_rem = r_rem - w_sub[15:0];
                    n_k   = r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        n_state = SQ_IDLE;
                    end
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_kind  <= n_kind;
        r_ch    <= n_ch;
        r_value <= n_value;
        r_rem   <= n_rem;
        r_k     <= n_k;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/light_command_text_parser.sv]
// ----------------------------------------------------------------------------
// light_command_text_parser
// Matches id, channel digit and topic of a text command, reads its value
// and streams back the state echo text.
// ----------------------------------------------------------------------------
// one message byte is accepted every cycle; a byte that ends a message
// stalls only while the previous finished command still waits in the queue
// first echo byte follows the queue slot, sequencer state and output register;
// one byte per cycle unless stalled, 6 to 20 bytes, paced by the sequencer
// synchronous active-low reset clears the parser, the sequencer and the
// configuration registers (id empty, cct bounds 2700 and 6500)
module light_command_text_parser import lctp_pkg::*; #(
    parameter int unsigned UID_MAX_CHARS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  t_in                    i_in,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output t_out                   o_out,
    input  logic                   i_out_stall,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic w_job_valid;
    t_job w_job;
    logic w_job_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uid_chars  <= '0;
            r_cfg.uid_length <= '0;
            r_cfg.cct_min    <= CCT_MIN_RESET;
            r_cfg.cct_max    <= CCT_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_UID_CHARS:  r_cfg.uid_chars  <= i_cfg_data;
                CFG_UID_LENGTH: r_cfg.uid_length <= i_cfg_data[3:0];
                CFG_CCT_MIN:    r_cfg.cct_min    <= i_cfg_data[15:0];
                CFG_CCT_MAX:    r_cfg.cct_max    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    lctp_parser #(
        .UID_MAX_CHARS(UID_MAX_CHARS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_take  (w_job_take)
    );

    lctp_echo #(
        .UID_MAX_CHARS(UID_MAX_CHARS)
    ) u_echo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_take  (w_job_take),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
